### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the lock block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, muted while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/core/bkpl_pkg.sv
// Types and constants of the binary keypad password lock.
package bkpl_pkg;

  localparam int PASSWORD_DIGITS = 4;
  localparam int ENTRY_W         = 2 * PASSWORD_DIGITS;
  localparam int COUNT_W         = $clog2(ENTRY_W + 1);

  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int ATTEMPTS_W = 2;
  localparam int LOCKOUT_W  = 6;
  localparam int IDLE_W     = 4;
  localparam int DIGITS_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [ATTEMPTS_W-1:0] ATTEMPTS_RST = ATTEMPTS_W'(3);
  localparam logic [LOCKOUT_W-1:0]  LOCKOUT_RST  = LOCKOUT_W'(60);
  localparam logic [IDLE_W-1:0]     IDLE_RST     = IDLE_W'(5);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_KEY    = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_LOGIN  = 2'd2,
    FUNC_CHANGE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_LOGIN   = 2'd1,
    MODE_CHANGE  = 2'd2,
    MODE_BLOCKED = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PENDING  = 3'd0,
    ST_LOGIN_OK = 3'd1,
    ST_WRONG    = 3'd2,
    ST_BLOCKED  = 3'd3,
    ST_TIMEOUT  = 3'd4,
    ST_CHANGED  = 3'd5,
    ST_MISMATCH = 3'd6
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTEMPTS = 2'd0,
    CFG_LOCKOUT  = 2'd1,
    CFG_IDLE     = 2'd2
  } cfg_idx_e;

endpackage

### rtl/core/binary_keypad_password_lock_top.sv
// Binary keypad password lock: session control, password compare and result register.
//
// Usage
//   Request channel: in_valid_i / in_stall_o with func_i (key press, one-second
//   tick, begin login, begin change) and key_bit_i (digit of a key press).
//   Result channel: out_valid_o / out_stall_i with status_o, attempts_remaining_o,
//   digits_entered_o and lockout_remaining_o; exactly one result per request.
//   Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
//   always ready; write only while no request is in flight.
// Timing
//   A request updates the lock state in the cycle it is accepted and its result
//   shows on the result register in the next cycle; one request per cycle while
//   out_stall_i stays low. The single result register sets that rate.
// Stall
//   While a result waits under out_stall_i, in_stall_o rises and the next request
//   waits; a result taken in the same cycle frees the register, so flow continues.
// Reset
//   rst_ni (async, active low) empties the result register, clears the stored
//   password and the entry, sets 3 attempts, idle count 5, no lockout, and loads
//   the registers with 3 attempts, 60 s lockout and 5 s idle timeout.
module binary_keypad_password_lock_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bkpl_pkg::FUNC_W-1:0]     func_i,
  input  logic                            key_bit_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bkpl_pkg::STATUS_W-1:0]   status_o,
  output logic [bkpl_pkg::ATTEMPTS_W-1:0] attempts_remaining_o,
  output logic [bkpl_pkg::DIGITS_W-1:0]   digits_entered_o,
  output logic [bkpl_pkg::LOCKOUT_W-1:0]  lockout_remaining_o,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bkpl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bkpl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bkpl_pkg::*;

  `include "assert_macros.svh"

  // configuration registers
  logic [ATTEMPTS_W-1:0] attempts_allowed_q;
  logic [LOCKOUT_W-1:0]  lockout_seconds_q;
  logic [IDLE_W-1:0]     idle_timeout_q;

  // lock state
  logic [PASSWORD_DIGITS-1:0] stored_pw_q, stored_pw_d;
  logic [ENTRY_W-1:0]         entry_q, entry_d;
  logic [COUNT_W-1:0]         count_q, count_d;
  logic [ATTEMPTS_W-1:0]      attempts_q, attempts_d;
  logic [IDLE_W-1:0]          idle_q, idle_d;
  logic [LOCKOUT_W-1:0]       lockout_q, lockout_d;
  mode_e                      mode_q, mode_d;

  // result register
  logic                  out_valid_q;
  status_e               res_status_q, res_status_d;
  logic [COUNT_W-1:0]    res_shown_q, res_shown_d;
  logic [ATTEMPTS_W-1:0] res_attempts_q;
  logic [LOCKOUT_W-1:0]  res_lockout_q;

  // request path helpers
  logic                  in_accept;
  func_e                 func;
  logic [ENTRY_W-1:0]    entry_shift;
  logic [COUNT_W-1:0]    count_inc;
  logic [COUNT_W-1:0]    need;
  logic [IDLE_W-1:0]     idle_reload;
  logic [LOCKOUT_W-1:0]  lockout_reload;
  logic [LOCKOUT_W-1:0]  lockout_dec;

  // Take a new request whenever the result register is empty or drains now.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign func           = func_e'(func_i);
  assign entry_shift    = {entry_q[ENTRY_W-2:0], key_bit_i};
  assign count_inc      = count_q + COUNT_W'(1);
  assign need           = (mode_q == MODE_LOGIN) ? COUNT_W'(PASSWORD_DIGITS)
                                                 : COUNT_W'(ENTRY_W);
  // A zero timeout register counts as one second.
  assign idle_reload    = (idle_timeout_q == '0) ? IDLE_W'(1) : idle_timeout_q;
  assign lockout_reload = (lockout_seconds_q == '0) ? LOCKOUT_W'(1) : lockout_seconds_q;
  assign lockout_dec    = (lockout_q != '0) ? lockout_q - LOCKOUT_W'(1) : lockout_q;

  // Next lock state and result of the request at the port.
  always_comb begin
    stored_pw_d  = stored_pw_q;
    entry_d      = entry_q;
    count_d      = count_q;
    attempts_d   = attempts_q;
    idle_d       = idle_q;
    lockout_d    = lockout_q;
    mode_d       = mode_q;
    res_status_d = ST_PENDING;
    res_shown_d  = '0;

    if (mode_q == MODE_BLOCKED) begin
      // Ignore everything but ticks; release the lock when the count runs out.
      res_status_d = ST_BLOCKED;
      if (func == FUNC_TICK) begin
        lockout_d = lockout_dec;
        if (lockout_dec == '0) begin
          mode_d       = MODE_IDLE;
          attempts_d   = attempts_allowed_q;
          res_status_d = ST_PENDING;
        end
      end
    end else if (func == FUNC_LOGIN || func == FUNC_CHANGE) begin
      mode_d = (func == FUNC_LOGIN) ? MODE_LOGIN : MODE_CHANGE;
      if (func == FUNC_LOGIN) begin
        attempts_d = attempts_allowed_q;
      end
      entry_d = '0;
      count_d = '0;
      idle_d  = idle_reload;
    end else if (mode_q == MODE_IDLE) begin
      // no session open: nothing to do
    end else if (func == FUNC_TICK) begin
      if (idle_q <= IDLE_W'(1)) begin
        idle_d       = '0;
        mode_d       = MODE_IDLE;
        entry_d      = '0;
        count_d      = '0;
        res_status_d = ST_TIMEOUT;
      end else begin
        idle_d = idle_q - IDLE_W'(1);
      end
    end else begin
      // Key press inside a session.
      entry_d     = entry_shift;
      count_d     = count_inc;
      idle_d      = idle_reload;
      res_shown_d = count_inc;
      if (count_inc >= need) begin
        if (mode_q == MODE_LOGIN) begin
          if (entry_shift[PASSWORD_DIGITS-1:0] == stored_pw_q) begin
            res_status_d = ST_LOGIN_OK;
            mode_d       = MODE_IDLE;
          end else if (attempts_q <= ATTEMPTS_W'(1)) begin
            attempts_d   = '0;
            lockout_d    = lockout_reload;
            mode_d       = MODE_BLOCKED;
            res_status_d = ST_BLOCKED;
          end else begin
            attempts_d   = attempts_q - ATTEMPTS_W'(1);
            res_status_d = ST_WRONG;
          end
        end else begin
          if (entry_shift[ENTRY_W-1:PASSWORD_DIGITS] == entry_shift[PASSWORD_DIGITS-1:0]) begin
            stored_pw_d  = entry_shift[PASSWORD_DIGITS-1:0];
            res_status_d = ST_CHANGED;
          end else begin
            res_status_d = ST_MISMATCH;
          end
          mode_d = MODE_IDLE;
        end
        entry_d = '0;
        count_d = '0;
      end
    end
  end

  // Configuration registers: indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attempts_allowed_q <= ATTEMPTS_RST;
      lockout_seconds_q  <= LOCKOUT_RST;
      idle_timeout_q     <= IDLE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ATTEMPTS: attempts_allowed_q <= cfg_data_i[ATTEMPTS_W-1:0];
        CFG_LOCKOUT:  lockout_seconds_q  <= cfg_data_i[LOCKOUT_W-1:0];
        CFG_IDLE:     idle_timeout_q     <= cfg_data_i[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Lock state: advance on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_pw_q <= '0;
      entry_q     <= '0;
      count_q     <= '0;
      attempts_q  <= ATTEMPTS_RST;
      idle_q      <= IDLE_RST;
      lockout_q   <= '0;
      mode_q      <= MODE_IDLE;
    end else if (in_accept) begin
      stored_pw_q <= stored_pw_d;
      entry_q     <= entry_d;
      count_q     <= count_d;
      attempts_q  <= attempts_d;
      idle_q      <= idle_d;
      lockout_q   <= lockout_d;
      mode_q      <= mode_d;
    end
  end

  // Result register valid: set on accept, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_status_q   <= res_status_d;
      res_shown_q    <= res_shown_d;
      res_attempts_q <= attempts_d;
      res_lockout_q  <= lockout_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = res_status_q;
  assign attempts_remaining_o = res_attempts_q;
  assign digits_entered_o     = DIGITS_W'(res_shown_q);
  assign lockout_remaining_o  = res_lockout_q;

  `ASSERT_CLK(a_accept_gives_result, (in_valid_i && !in_stall_o) |=> out_valid_o, "accepted request left no result")
  `ASSERT_CLK(a_lockout_iff_blocked, (mode_q == MODE_BLOCKED) == (lockout_q != '0), "lockout count out of step with blocked mode")
  `ASSERT_ALWAYS(a_blocked_no_attempts, (mode_q == MODE_BLOCKED) |-> (attempts_q == '0), "attempts left while blocked")
  `ASSERT_ALWAYS(a_no_entry_outside_session, (mode_q == MODE_IDLE || mode_q == MODE_BLOCKED) |-> (count_q == '0), "entry open outside a session")
  `ASSERT_ALWAYS(a_login_count_bound, (mode_q == MODE_LOGIN) |-> (count_q < COUNT_W'(PASSWORD_DIGITS)), "login entry overran its length")

endmodule

### tb/sv/tb_binary_keypad_password_lock_top.sv
// Self-checking testbench of the binary keypad password lock, with its own model of the lock.
module tb_binary_keypad_password_lock_top;
  import bkpl_pkg::*;

  // One response of the lock, as the result channel carries it.
  typedef struct packed {
    status_e                 status;
    logic [ATTEMPTS_W-1:0]   attempts;
    logic [DIGITS_W-1:0]     digits;
    logic [LOCKOUT_W-1:0]    lockout;
  } lock_resp_t;

  // Clock, reset and block ports; drive every input to a known value from time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [FUNC_W-1:0]     func_i      = FUNC_KEY;
  logic                  key_bit_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [ATTEMPTS_W-1:0] attempts_remaining_o;
  logic [DIGITS_W-1:0]   digits_entered_o;
  logic [LOCKOUT_W-1:0]  lockout_remaining_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_ATTEMPTS;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Model of the lock: stored code, open entry, counters and session mode.
  logic [PASSWORD_DIGITS-1:0] saved_code    = '0;
  logic [ENTRY_W-1:0]         entry_shift   = '0;
  logic [COUNT_W-1:0]         entry_count   = '0;
  logic [ATTEMPTS_W-1:0]      tries_left    = ATTEMPTS_RST;
  logic [IDLE_W-1:0]          idle_count    = IDLE_RST;
  logic [LOCKOUT_W-1:0]       lockout_count = '0;
  mode_e                      lock_mode     = MODE_IDLE;

  // Model copy of the configuration registers, loaded with their reset values.
  logic [ATTEMPTS_W-1:0] max_attempts = ATTEMPTS_RST;
  logic [LOCKOUT_W-1:0]  lockout_len  = LOCKOUT_RST;
  logic [IDLE_W-1:0]     idle_len     = IDLE_RST;

  // Responses predicted for accepted requests, oldest first.
  lock_resp_t pending_responses[$];

  // Flow-control pressure in percent per cycle.
  int send_idle_pct = 29;
  int stall_pct     = 52;

  int err_count   = 0;
  int items_sent  = 0;
  int cfg_writes  = 0;
  int checked     = 0;
  int status_hits[0:6] = '{default: 0};

  binary_keypad_password_lock_top u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .func_i               (func_i),
    .key_bit_i            (key_bit_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_o             (status_o),
    .attempts_remaining_o (attempts_remaining_o),
    .digits_entered_o     (digits_entered_o),
    .lockout_remaining_o  (lockout_remaining_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Idle count reload; a zero timeout counts as one second.
  function automatic logic [IDLE_W-1:0] idle_reload();
    return (idle_len == '0) ? IDLE_W'(1) : idle_len;
  endfunction

  // Advance the lock model by one request and return the response it gives.
  function automatic lock_resp_t predict_lock_response(func_e f, logic b);
    lock_resp_t r;
    int         need;
    r.status = ST_PENDING;
    r.digits = '0;
    if (lock_mode == MODE_BLOCKED) begin
      // While blocked, only ticks matter: they run the lockout down.
      r.status = ST_BLOCKED;
      if (f == FUNC_TICK) begin
        if (lockout_count != '0) lockout_count = lockout_count - 1'b1;
        if (lockout_count == '0) begin
          lock_mode  = MODE_IDLE;
          tries_left = max_attempts;
          r.status   = ST_PENDING;
        end
      end
    end else if (f == FUNC_LOGIN || f == FUNC_CHANGE) begin
      lock_mode = (f == FUNC_LOGIN) ? MODE_LOGIN : MODE_CHANGE;
      if (f == FUNC_LOGIN) tries_left = max_attempts;
      entry_shift = '0;
      entry_count = '0;
      idle_count  = idle_reload();
    end else if (lock_mode == MODE_IDLE) begin
      // no session open: keys and ticks leave everything as it is
    end else if (f == FUNC_TICK) begin
      if (idle_count <= IDLE_W'(1)) begin
        idle_count  = '0;
        lock_mode   = MODE_IDLE;
        entry_shift = '0;
        entry_count = '0;
        r.status    = ST_TIMEOUT;
      end else begin
        idle_count = idle_count - 1'b1;
      end
    end else begin
      // Key press: shift the digit in, first digit ends up most significant.
      entry_shift = {entry_shift[ENTRY_W-2:0], b};
      entry_count = entry_count + 1'b1;
      idle_count  = idle_reload();
      r.digits    = DIGITS_W'(entry_count);
      need        = (lock_mode == MODE_LOGIN) ? PASSWORD_DIGITS : ENTRY_W;
      if (entry_count >= need) begin
        if (lock_mode == MODE_LOGIN) begin
          if (entry_shift[PASSWORD_DIGITS-1:0] == saved_code) begin
            r.status  = ST_LOGIN_OK;
            lock_mode = MODE_IDLE;
          end else if (tries_left <= ATTEMPTS_W'(1)) begin
            tries_left    = '0;
            lockout_count = (lockout_len == '0) ? LOCKOUT_W'(1) : lockout_len;
            lock_mode     = MODE_BLOCKED;
            r.status      = ST_BLOCKED;
          end else begin
            tries_left = tries_left - 1'b1;
            r.status   = ST_WRONG;
          end
        end else begin
          if (entry_shift[ENTRY_W-1:PASSWORD_DIGITS] == entry_shift[PASSWORD_DIGITS-1:0]) begin
            saved_code = entry_shift[PASSWORD_DIGITS-1:0];
            r.status   = ST_CHANGED;
          end else begin
            r.status = ST_MISMATCH;
          end
          lock_mode = MODE_IDLE;
        end
        entry_shift = '0;
        entry_count = '0;
      end
    end
    r.attempts = tries_left;
    r.lockout  = lockout_count;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Result side: raise stall at random, per the current pressure.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Result side: take each accepted response and hold it against the oldest prediction.
  always @(posedge clk_i) begin : check_responses
    lock_resp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("response with status %0d while none is expected",
                                  status_o));
      end else begin
        want = pending_responses.pop_front();
        checked++;
        status_hits[want.status]++;
        if (status_o !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (attempts_remaining_o !== want.attempts)
          report_mismatch($sformatf("attempts_remaining got %0d want %0d",
                                    attempts_remaining_o, want.attempts));
        if (digits_entered_o !== want.digits)
          report_mismatch($sformatf("digits_entered got %0d want %0d",
                                    digits_entered_o, want.digits));
        if (lockout_remaining_o !== want.lockout)
          report_mismatch($sformatf("lockout_remaining got %0d want %0d",
                                    lockout_remaining_o, want.lockout));
      end
    end
  end

  // Send one request; call right after a rising edge. Idle first at random,
  // then hold valid and payload until the lock takes the request.
  task automatic send_request(func_e f, logic b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    key_bit_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    pending_responses.push_back(predict_lock_response(f, b));
    items_sent++;
  endtask

  // Key in the top digits of a code, first digit most significant; drop in a tick now and then.
  task automatic enter_code(logic [PASSWORD_DIGITS-1:0] code, int digits);
    for (int i = PASSWORD_DIGITS - 1; i >= PASSWORD_DIGITS - digits; i--) begin
      if ($urandom_range(0, 99) < 6) send_request(FUNC_TICK, 1'($urandom_range(0, 1)));
      send_request(FUNC_KEY, code[i]);
    end
  endtask

  // Drop valid and let every predicted response come out, then idle for a margin.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write one register; call only while drained.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ATTEMPTS: max_attempts = data[ATTEMPTS_W-1:0];
      CFG_LOCKOUT:  lockout_len  = data[LOCKOUT_W-1:0];
      CFG_IDLE:     idle_len     = data[IDLE_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Keys and ticks with no session open change nothing.
  task automatic test_idle_requests();
    send_request(FUNC_KEY, 1'b1);
    send_request(FUNC_TICK, 1'b0);
  endtask

  // Change session whose two halves differ: all ones, then all zeros.
  task automatic test_change_mismatch();
    send_request(FUNC_CHANGE, 1'b1);
    enter_code('1, PASSWORD_DIGITS);
    enter_code('0, PASSWORD_DIGITS);
  endtask

  // Log in with the code the lock holds after reset.
  task automatic test_default_login();
    send_request(FUNC_LOGIN, 1'b0);
    enter_code('0, PASSWORD_DIGITS);
  endtask

  // One allowed attempt: a wrong code blocks at once. Keys and begin requests
  // bounce off the lockout, then two ticks release it.
  task automatic test_lockout();
    wait_drained();
    write_reg(CFG_ATTEMPTS, 6'd1);
    write_reg(CFG_LOCKOUT, 6'd2);
    send_request(FUNC_LOGIN, 1'b0);
    enter_code('1, PASSWORD_DIGITS);
    send_request(FUNC_KEY, 1'b1);
    send_request(FUNC_LOGIN, 1'b0);
    send_request(FUNC_TICK, 1'b0);
    send_request(FUNC_TICK, 1'b1);
  endtask

  // One-second idle timeout: the first tick ends the session.
  task automatic test_idle_timeout();
    wait_drained();
    write_reg(CFG_IDLE, 6'd1);
    send_request(FUNC_LOGIN, 1'b1);
    send_request(FUNC_TICK, 1'b0);
  endtask

  // Load one register setting: upper extremes, lower extremes, zeros, mixed, raw random, else reset values.
  task automatic apply_setting(int which);
    case (which)
      0: begin
        write_reg(CFG_ATTEMPTS, 6'd3);
        write_reg(CFG_LOCKOUT, 6'd63);
        write_reg(CFG_IDLE, 6'd15);
      end
      1: begin
        write_reg(CFG_ATTEMPTS, 6'd1);
        write_reg(CFG_LOCKOUT, 6'd1);
        write_reg(CFG_IDLE, 6'd1);
      end
      2: begin
        write_reg(CFG_ATTEMPTS, 6'd0);
        write_reg(CFG_LOCKOUT, 6'd0);
        write_reg(CFG_IDLE, 6'd0);
      end
      3: begin
        write_reg(CFG_ATTEMPTS, 6'd2);
        write_reg(CFG_LOCKOUT, 6'($urandom_range(1, 63)));
        write_reg(CFG_IDLE, 6'($urandom_range(1, 15)));
      end
      4: begin
        write_reg(CFG_ATTEMPTS, 6'($urandom));
        write_reg(CFG_LOCKOUT, 6'($urandom));
        write_reg(CFG_IDLE, 6'($urandom));
      end
      default: begin
        write_reg(CFG_ATTEMPTS, 6'd3);
        write_reg(CFG_LOCKOUT, 6'd60);
        write_reg(CFG_IDLE, 6'd5);
      end
    endcase
  endtask

  // Mostly whole login and change sessions with random codes, mixed with tick
  // bursts, abandoned entries and stray requests. While blocked, mostly tick.
  task automatic run_random_traffic(int count);
    int                         stop;
    int                         pick;
    int                         tries;
    logic [PASSWORD_DIGITS-1:0] code_a;
    logic [PASSWORD_DIGITS-1:0] code_b;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (lock_mode == MODE_BLOCKED) begin
        if (pick < 85) send_request(FUNC_TICK, 1'($urandom_range(0, 1)));
        else send_request(func_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (pick < 40) begin
        // keep trying while the session stays open; right code a bit under half the time
        send_request(FUNC_LOGIN, 1'($urandom_range(0, 1)));
        tries = 0;
        while (lock_mode == MODE_LOGIN && tries < 4) begin
          code_a = ($urandom_range(0, 99) < 45) ? saved_code : PASSWORD_DIGITS'($urandom);
          enter_code(code_a, PASSWORD_DIGITS);
          tries++;
        end
      end else if (pick < 68) begin
        send_request(FUNC_CHANGE, 1'($urandom_range(0, 1)));
        code_a = PASSWORD_DIGITS'($urandom);
        code_b = ($urandom_range(0, 99) < 60) ? code_a : PASSWORD_DIGITS'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          enter_code(code_a, $urandom_range(1, PASSWORD_DIGITS));
        end else begin
          enter_code(code_a, PASSWORD_DIGITS);
          enter_code(code_b, PASSWORD_DIGITS);
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 17)) send_request(FUNC_TICK, 1'($urandom_range(0, 1)));
      end else begin
        send_request(func_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Three pressure profiles, two register settings each.
  task automatic test_random_traffic();
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 29; stall_pct = 52; end
        1: begin send_idle_pct = 52; stall_pct = 29; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      for (int s = 0; s < 2; s++) begin
        wait_drained();
        apply_setting(2 * p + s);
        run_random_traffic(145);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_requests();
    test_change_mismatch();
    test_default_login();
    test_lockout();
    test_idle_timeout();
    test_random_traffic();

    wait_drained();
    $display("Covered %0d requests and %0d register writes under three flow-control profiles",
             items_sent, cfg_writes);
    $display("Checked %0d responses: %0d logins, %0d wrong, %0d blocked, %0d timeouts, %0d changes, %0d mismatches",
             checked, status_hits[ST_LOGIN_OK], status_hits[ST_WRONG], status_hits[ST_BLOCKED],
             status_hits[ST_TIMEOUT], status_hits[ST_CHANGED], status_hits[ST_MISMATCH]);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: end a run that hangs on a handshake.
  initial begin
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
